@@ rtl/cnalu_pkg.sv @@
// ----------------------------------------------------------------------------
// cnalu_pkg
// commands and status codes; the per-item payload carried along the cell chain is defined in complex_number_alu_top
// ----------------------------------------------------------------------------
package cnalu_pkg;

   localparam int CMD_BITS = 4;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_EQ  = 4'd0,
      CMD_NE  = 4'd1,
      CMD_AND = 4'd2,
      CMD_OR  = 4'd3,
      CMD_ADD = 4'd4,
      CMD_SUB = 4'd5,
      CMD_MUL = 4'd6,
      CMD_DIV = 4'd7,
      CMD_DVB = 4'd8
   } cmd_type;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_SAT = 2'd1;
   localparam logic [1:0] ST_DBZ = 2'd2;

endpackage

@@ rtl/cnalu_div_cell.sv @@
// ----------------------------------------------------------------------------
// cnalu_div_cell
// one restoring-division step for both quotient parts, registered
// ----------------------------------------------------------------------------
module cnalu_div_cell
   import cnalu_pkg::*;
#(
   parameter int NB = 128,
   parameter int STEP = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          v_in,
   input  logic [NB-1:0] den_in,
   input  logic [NB-1:0] nr_in,
   input  logic [NB-1:0] ni_in,
   input  logic [NB-1:0] rr_in,
   input  logic [NB-1:0] ri_in,
   input  logic [NB-1:0] qr_in,
   input  logic [NB-1:0] qi_in,
   output logic          v_ff,
   output logic [NB-1:0] den_ff,
   output logic [NB-1:0] nr_ff,
   output logic [NB-1:0] ni_ff,
   output logic [NB-1:0] rr_ff,
   output logic [NB-1:0] ri_ff,
   output logic [NB-1:0] qr_ff,
   output logic [NB-1:0] qi_ff
);
   localparam int BIT = NB - 1 - STEP;
   logic [NB:0] tr, ti, dr, di;
   logic [NB-1:0] rr_nx, ri_nx, qr_nx, qi_nx;

   always_comb begin
      tr = {rr_in, nr_in[BIT]};
      ti = {ri_in, ni_in[BIT]};
      dr = tr - {1'b0, den_in};
      di = ti - {1'b0, den_in};
      rr_nx = dr[NB] ? tr[NB-1:0] : dr[NB-1:0];
      ri_nx = di[NB] ? ti[NB-1:0] : di[NB-1:0];
      qr_nx = qr_in;
      qi_nx = qi_in;
      qr_nx[BIT] = ~dr[NB];
      qi_nx[BIT] = ~di[NB];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= v_in;
      end
      if (en) begin
         den_ff <= den_in;
         nr_ff  <= nr_in;
         ni_ff  <= ni_in;
         rr_ff  <= rr_nx;
         ri_ff  <= ri_nx;
         qr_ff  <= qr_nx;
         qi_ff  <= qi_nx;
      end
   end
endmodule

@@ rtl/complex_number_alu_top.sv @@
// ----------------------------------------------------------------------------
// complex_number_alu_top
// complex compare / add / sub / mul / div unit in signed fixed point
// ----------------------------------------------------------------------------
// path: capture, products, sums, scaling, division cell chain, output register, all registered
// throughput: one transaction per cycle, except while a stalled result holds the chain
// the whole chain advances when the output register is free or taken
// reset clears all valid bits, payload registers are not reset
module complex_number_alu_top
   import cnalu_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // command, a_re, a_im, b_re, b_im
   input  logic [((CMD_BITS+4*WORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // res_re, res_im, truth, status
   output logic [((2*WORD_BITS+3+7)/8)*8-1:0] rsp_tdata
);
   localparam int W   = WORD_BITS;
   localparam int P   = 2 * W;
   localparam int NB  = 2 * W + 2 + FRAC_BITS;
   localparam int ND  = NB;
   localparam int OW  = ((2*W+3+7)/8)*8;

   logic en;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // stage 0: capture
   logic                v0_ff;
   logic [CMD_BITS-1:0] c0_ff;
   logic signed [W-1:0] ar0_ff, ai0_ff, br0_ff, bi0_ff;

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (en) v0_ff <= req_tvalid;
      if (en) begin
         c0_ff  <= req_tdata[CMD_BITS-1:0];
         ar0_ff <= req_tdata[CMD_BITS +: W];
         ai0_ff <= req_tdata[CMD_BITS+W +: W];
         br0_ff <= req_tdata[CMD_BITS+2*W +: W];
         bi0_ff <= req_tdata[CMD_BITS+3*W +: W];
      end
   end

   // stage 1: six products
   logic                v1_ff;
   logic [CMD_BITS-1:0] c1_ff;
   logic signed [W-1:0] ar1_ff, ai1_ff, br1_ff, bi1_ff;
   logic signed [P-1:0] p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff, p_bb_ff, p_cc_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= v0_ff;
      if (en) begin
         c1_ff <= c0_ff;
         ar1_ff <= ar0_ff; ai1_ff <= ai0_ff; br1_ff <= br0_ff; bi1_ff <= bi0_ff;
         p_rr_ff <= P'(ar0_ff) * P'(br0_ff);
         p_ii_ff <= P'(ai0_ff) * P'(bi0_ff);
         p_ir_ff <= P'(ai0_ff) * P'(br0_ff);
         p_ri_ff <= P'(ar0_ff) * P'(bi0_ff);
         p_bb_ff <= P'(br0_ff) * P'(br0_ff);
         p_cc_ff <= P'(bi0_ff) * P'(bi0_ff);
      end
   end

   // stage 2: sums, small results
   logic signed [P+1:0] s_mr_in, s_mi_in, s_dr_in, s_di_in;
   logic [P+1:0]        den_in2;
   logic signed [W:0]   sum_r_in, sum_i_in;
   logic                truth_in, bnz, anz;

   always_comb begin
      s_mr_in = (P+2)'(p_rr_ff) - (P+2)'(p_ii_ff);
      s_mi_in = (P+2)'(p_ir_ff) + (P+2)'(p_ri_ff);
      s_dr_in = (P+2)'(p_rr_ff) + (P+2)'(p_ii_ff);
      s_di_in = (P+2)'(p_ir_ff) - (P+2)'(p_ri_ff);
      den_in2 = (P+2)'($unsigned(p_bb_ff)) + (P+2)'($unsigned(p_cc_ff));
      anz = (ar1_ff != '0) || (ai1_ff != '0);
      bnz = (br1_ff != '0) || (bi1_ff != '0);
      sum_r_in = '0;
      sum_i_in = '0;
      truth_in = 1'b0;
      case (c1_ff)
         CMD_EQ:  truth_in = (ar1_ff == br1_ff) && (ai1_ff == bi1_ff);
         CMD_NE:  truth_in = (ar1_ff != br1_ff) || (ai1_ff != bi1_ff);
         CMD_AND: truth_in = anz && bnz;
         CMD_OR:  truth_in = anz || bnz;
         CMD_DVB: truth_in = bnz;
         CMD_ADD: begin
            sum_r_in = (W+1)'(ar1_ff) + (W+1)'(br1_ff);
            sum_i_in = (W+1)'(ai1_ff) + (W+1)'(bi1_ff);
         end
         CMD_SUB: begin
            sum_r_in = (W+1)'(ar1_ff) - (W+1)'(br1_ff);
            sum_i_in = (W+1)'(ai1_ff) - (W+1)'(bi1_ff);
         end
         default: truth_in = 1'b0;
      endcase
   end

   logic                v2_ff, t2_ff, bnz2_ff;
   logic [CMD_BITS-1:0] c2_ff;
   logic signed [W:0]   sr2_ff, si2_ff;
   logic signed [P+1:0] mr2_ff, mi2_ff, dr2_ff, di2_ff;
   logic [P+1:0]        den2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
      if (en) begin
         c2_ff <= c1_ff; t2_ff <= truth_in; bnz2_ff <= bnz;
         sr2_ff <= sum_r_in; si2_ff <= sum_i_in;
         mr2_ff <= s_mr_in; mi2_ff <= s_mi_in;
         dr2_ff <= s_dr_in; di2_ff <= s_di_in;
         den2_ff <= den_in2;
      end
   end

   // stage 3: magnitudes and scaled numerators
   logic [P+1:0]  mmr_in, mmi_in;
   logic [NB-1:0] nr_in, ni_in;
   always_comb begin
      mmr_in = mr2_ff[P+1] ? (P+2)'(-mr2_ff) : mr2_ff;
      mmi_in = mi2_ff[P+1] ? (P+2)'(-mi2_ff) : mi2_ff;
      nr_in  = NB'(dr2_ff[P+1] ? (P+2)'(-dr2_ff) : dr2_ff) << FRAC_BITS;
      ni_in  = NB'(di2_ff[P+1] ? (P+2)'(-di2_ff) : di2_ff) << FRAC_BITS;
   end

   typedef struct packed {
      logic [CMD_BITS-1:0] cmd;
      logic                truth;
      logic                bnz;
      logic                ngr;
      logic                ngi;
      logic [W:0]          sr;
      logic [W:0]          si;
   } side_type;

   logic                v3_ff;
   side_type            sd3_ff;
   logic [P+1:0]        sh3r_ff, sh3i_ff;
   logic [NB-1:0]       nr3_ff, ni3_ff, den3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
      if (en) begin
         sd3_ff.cmd <= c2_ff; sd3_ff.truth <= t2_ff; sd3_ff.bnz <= bnz2_ff;
         if (c2_ff == CMD_MUL) begin
            sd3_ff.ngr <= mr2_ff[P+1]; sd3_ff.ngi <= mi2_ff[P+1];
         end else begin
            sd3_ff.ngr <= dr2_ff[P+1]; sd3_ff.ngi <= di2_ff[P+1];
         end
         sd3_ff.sr <= sr2_ff; sd3_ff.si <= si2_ff;
         sh3r_ff <= mmr_in >> FRAC_BITS;
         sh3i_ff <= mmi_in >> FRAC_BITS;
         nr3_ff <= nr_in; ni3_ff <= ni_in;
         den3_ff <= NB'(den2_ff);
      end
   end

   // division cell chain
   logic          cv  [ND+1];
   logic [NB-1:0] cden[ND+1], cnr[ND+1], cni[ND+1];
   logic [NB-1:0] crr [ND+1], cri[ND+1], cqr[ND+1], cqi[ND+1];
   side_type      csd [ND+1];
   logic [P+1:0]  cmr [ND+1], cmi[ND+1];

   assign cv[0] = v3_ff; assign cden[0] = den3_ff;
   assign cnr[0] = nr3_ff; assign cni[0] = ni3_ff;
   assign crr[0] = '0; assign cri[0] = '0; assign cqr[0] = '0; assign cqi[0] = '0;
   assign csd[0] = sd3_ff; assign cmr[0] = sh3r_ff; assign cmi[0] = sh3i_ff;

   for (genvar k = 0; k < ND; k++) begin : g_cell
      cnalu_div_cell #(.NB(NB), .STEP(k)) u_cell (
         .clock(clock), .reset(reset), .en(en), .v_in(cv[k]),
         .den_in(cden[k]), .nr_in(cnr[k]), .ni_in(cni[k]),
         .rr_in(crr[k]), .ri_in(cri[k]), .qr_in(cqr[k]), .qi_in(cqi[k]),
         .v_ff(cv[k+1]), .den_ff(cden[k+1]), .nr_ff(cnr[k+1]), .ni_ff(cni[k+1]),
         .rr_ff(crr[k+1]), .ri_ff(cri[k+1]), .qr_ff(cqr[k+1]), .qi_ff(cqi[k+1])
      );
      always_ff @(posedge clock) begin
         if (en) begin
            csd[k+1] <= csd[k];
            cmr[k+1] <= cmr[k];
            cmi[k+1] <= cmi[k];
         end
      end
   end

   // sign restore and saturation
   side_type      sd;
   logic [NB:0]   magr, magi, vr, vi;
   logic [W-1:0]  or_in, oi_in;
   logic          ovr, ovi, truth_o;
   logic [1:0]    st_in;
   localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

   always_comb begin
      sd = csd[ND];
      if (sd.cmd == CMD_MUL) begin
         magr = (NB+1)'(cmr[ND]); magi = (NB+1)'(cmi[ND]);
      end else begin
         magr = (NB+1)'(cqr[ND]); magi = (NB+1)'(cqi[ND]);
      end
      vr = sd.ngr ? (NB+1)'(-magr) : magr;
      vi = sd.ngi ? (NB+1)'(-magi) : magi;
      if ((sd.cmd == CMD_ADD) || (sd.cmd == CMD_SUB)) begin
         vr = (NB+1)'($signed(sd.sr)); vi = (NB+1)'($signed(sd.si));
      end
      ovr = (vr[NB:W-1] != '0) && (vr[NB:W-1] != '1);
      ovi = (vi[NB:W-1] != '0) && (vi[NB:W-1] != '1);
      or_in = ovr ? (vr[NB] ? MINV : MAXV) : vr[W-1:0];
      oi_in = ovi ? (vi[NB] ? MINV : MAXV) : vi[W-1:0];
      truth_o = sd.truth;
      st_in = ST_OK;
      case (sd.cmd)
         CMD_ADD, CMD_SUB, CMD_MUL: begin
            if (ovr || ovi) st_in = ST_SAT;
         end
         CMD_DIV: begin
            if (!sd.bnz) begin
               st_in = ST_DBZ; or_in = '0; oi_in = '0;
            end else if (ovr || ovi) begin
               st_in = ST_SAT;
            end
         end
         default: begin
            or_in = '0; oi_in = '0;
         end
      endcase
   end

   logic          ov_ff;
   logic [OW-1:0] od_ff;
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (en) ov_ff <= cv[ND];
      if (en) od_ff <= OW'({st_in, truth_o, oi_in, or_in});
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
endmodule

@@ rtl/cnalu_checker.sv @@
// ----------------------------------------------------------------------------
// cnalu_checker
// port-level checks for the complex arithmetic unit
// ----------------------------------------------------------------------------
module cnalu_checker
   import cnalu_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[66:65] <= ST_DBZ)
      else $error("bad status code");
   a_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[64] |-> rsp_tdata[63:0] == '0 && rsp_tdata[66:65] == ST_OK)
      else $error("compare result carries data");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("valid after reset");
endmodule

bind complex_number_alu_top cnalu_checker u_cnalu_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

@@ dv/complex_number_alu_top_tb.sv @@
// ----------------------------------------------------------------------------
// complex_number_alu_top_tb
// drives command and operand transactions with random idling on both sides
// and checks each result against a table entry or full-width fixed-point model
// ----------------------------------------------------------------------------
module complex_number_alu_top_tb
   import cnalu_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WB = 32;
   localparam int FB = 16;
   localparam int REQ_W = ((CMD_BITS + 4 * WB + 7) / 8) * 8;
   localparam int RSP_W = ((2 * WB + 3 + 7) / 8) * 8;
   localparam int PIPE_LAT = 2 * WB + FB + 6;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [CMD_BITS-1:0] CMD_UNKNOWN = 4'd12;
   localparam logic [CMD_BITS-1:0] CMD_SPARE = 4'hf;

   typedef struct packed {
      logic signed [WB-1:0] b_im;
      logic signed [WB-1:0] b_re;
      logic signed [WB-1:0] a_im;
      logic signed [WB-1:0] a_re;
      logic [CMD_BITS-1:0] cmd;
   } operands_type;

   typedef struct packed {
      logic [1:0] status;
      logic truth;
      logic signed [WB-1:0] res_im;
      logic signed [WB-1:0] res_re;
   } outcome_type;

   typedef struct {
      operands_type op;
      bit known;
      outcome_type res;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   // command, a_re, a_im, b_re, b_im
   // res_re, res_im, truth, status
   complex_number_alu_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   outcome_type pending_results[$];
   vector_type directed[$];
   int error_count = 0;
   int cycles = 0;
   int stall_left = 0;
   bit calm = 1'b0;

   task automatic report(input string what);
      $display("mismatch at cycle %0d: %s", cycles, what);
      error_count++;
   endtask

   function automatic logic signed [WB-1:0] clamp(input logic signed [255:0] x,
                                                  inout bit sat);
      if (x > $signed(256'(32'sh7fffffff)) || x < -$signed(256'h80000000)) begin
         sat = 1'b1;
         return x[255] ? {1'b1, {(WB-1){1'b0}}} : {1'b0, {(WB-1){1'b1}}};
      end
      return x[WB-1:0];
   endfunction

   function automatic logic signed [255:0] trunc_div(input logic signed [255:0] n,
                                                     input logic signed [255:0] d);
      logic [255:0] mag;
      mag = n[255] ? -n : n;
      mag = (mag << FB) / d;
      return n[255] ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic outcome_type complex_alu(input operands_type op);
      outcome_type r;
      logic signed [255:0] ar, ai, br, bi, xr, xi, den;
      bit anz, bnz, arith, sat;
      ar = op.a_re; ai = op.a_im; br = op.b_re; bi = op.b_im;
      anz = (op.a_re != 0) || (op.a_im != 0);
      bnz = (op.b_re != 0) || (op.b_im != 0);
      r = '0; arith = 0; sat = 0; xr = 0; xi = 0;
      case (op.cmd)
         CMD_EQ: r.truth = (op.a_re == op.b_re) && (op.a_im == op.b_im);
         CMD_NE: r.truth = (op.a_re != op.b_re) || (op.a_im != op.b_im);
         CMD_AND: r.truth = anz && bnz;
         CMD_OR: r.truth = anz || bnz;
         CMD_ADD: begin xr = ar + br; xi = ai + bi; arith = 1; end
         CMD_SUB: begin xr = ar - br; xi = ai - bi; arith = 1; end
         CMD_MUL: begin
            xr = (ar * br - ai * bi) / $signed(256'(1 << FB));
            xi = (ai * br + ar * bi) / $signed(256'(1 << FB));
            arith = 1;
         end
         CMD_DIV: begin
            if (!bnz) r.status = ST_DBZ;
            else begin
               den = br * br + bi * bi;
               xr = trunc_div(ar * br + ai * bi, den);
               xi = trunc_div(ai * br - ar * bi, den);
               arith = 1;
            end
         end
         CMD_DVB: r.truth = bnz;
         default: ;
      endcase
      if (arith) begin
         r.res_re = clamp(xr, sat);
         r.res_im = clamp(xi, sat);
         if (sat) r.status = ST_SAT;
      end
      return r;
   endfunction

   function automatic logic signed [WB-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 0;
         3: return $signed(32'($urandom_range(0, 8))) << FB;
         4: return -($signed(32'($urandom_range(0, 8))) << FB);
         5: return $signed(32'($urandom_range(0, 2 ** 20))) - (1 << 19);
         default: return $urandom;
      endcase
   endfunction

   function automatic vector_type row(input logic [CMD_BITS-1:0] c, input int ar, input int ai,
                                      input int br, input int bi, input bit known,
                                      input outcome_type res);
      vector_type v;
      v.op = '{b_im: bi, b_re: br, a_im: ai, a_re: ar, cmd: c};
      v.known = known;
      v.res = res;
      return v;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout");
         $display("complex_number_alu_top_tb: errors");
         $finish;
      end
   end

   // result side
   always @(posedge clock) begin
      outcome_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(outcome_type)-1:0];
         if (pending_results.size() == 0) report("result with nothing pending");
         else begin
            want = pending_results.pop_front();
            if (got.res_re !== want.res_re)
               report($sformatf("res_re %h want %h", got.res_re, want.res_re));
            if (got.res_im !== want.res_im)
               report($sformatf("res_im %h want %h", got.res_im, want.res_im));
            if (got.truth !== want.truth)
               report($sformatf("truth %b want %b", got.truth, want.truth));
            if (got.status !== want.status)
               report($sformatf("status %0d want %0d", got.status, want.status));
         end
      end
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 1) begin
         stall_left--;
      end else if (stall_left == 1) begin
         stall_left = 0;
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      int k, gap;
      operands_type op;
      outcome_type z;
      z = '0;
      directed.push_back(row(CMD_EQ, 0, 0, 0, 0, 1, '{status: ST_OK, truth: 1, default: 0}));
      directed.push_back(row(CMD_EQ, 5, 1, 5, 2, 1, z));
      directed.push_back(row(CMD_NE, 5, 1, 5, 2, 1, '{status: ST_OK, truth: 1, default: 0}));
      directed.push_back(row(CMD_AND, 0, 0, 1, 0, 1, z));
      directed.push_back(row(CMD_AND, 0, -1, 1, 0, 1, '{status: ST_OK, truth: 1, default: 0}));
      directed.push_back(row(CMD_OR, 0, 0, 0, 0, 1, z));
      directed.push_back(row(CMD_OR, 0, 0, 0, 7, 1, '{status: ST_OK, truth: 1, default: 0}));
      directed.push_back(row(CMD_ADD, 32'h7fffffff, 0, 1, 0, 1,
         '{status: ST_SAT, truth: 0, res_im: 0, res_re: 32'h7fffffff}));
      directed.push_back(row(CMD_ADD, 32'h80000000, 0, -1, 0, 1,
         '{status: ST_SAT, truth: 0, res_im: 0, res_re: 32'h80000000}));
      directed.push_back(row(CMD_SUB, 10, 3, 4, 1, 1,
         '{status: ST_OK, truth: 0, res_im: 2, res_re: 6}));
      directed.push_back(row(CMD_SUB, 32'h80000000, 32'h7fffffff, 1, -1, 0, z));
      directed.push_back(row(CMD_MUL, 32'h20000, 32'h10000, 32'h30000, -32'h10000, 0, z));
      directed.push_back(row(CMD_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                             0, z));
      directed.push_back(row(CMD_MUL, -3, 0, 1, 0, 0, z));
      directed.push_back(row(CMD_DIV, 32'h10000, 0, 0, 0, 1,
         '{status: ST_DBZ, truth: 0, res_im: 0, res_re: 0}));
      directed.push_back(row(CMD_DIV, 32'h40000, 32'h20000, 32'h10000, 32'h10000, 0, z));
      directed.push_back(row(CMD_DIV, 32'h7fffffff, 32'h80000000, 1, 0, 0, z));
      directed.push_back(row(CMD_DIV, -7, 3, 32'h7fffffff, 32'h80000000, 0, z));
      directed.push_back(row(CMD_DVB, 1, 1, 0, 0, 1, z));
      directed.push_back(row(CMD_DVB, 0, 0, 0, 1, 1, '{status: ST_OK, truth: 1, default: 0}));
      directed.push_back(row(CMD_UNKNOWN, 9, 9, 9, 9, 1, z));
      directed.push_back(row(CMD_SPARE, -1, -1, -1, -1, 1, z));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (k = 0; k < directed.size() + 1200; k++) begin
         if (k < directed.size()) begin
            op = directed[k].op;
            pending_results.push_back(directed[k].known ? directed[k].res : complex_alu(op));
         end else begin
            op.cmd = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                                  : 4'($urandom_range(0, 8));
            op.a_re = pick_word(); op.a_im = pick_word();
            op.b_re = pick_word(); op.b_im = pick_word();
            if (op.cmd <= CMD_NE && $urandom_range(0, 2) == 0) begin
               op.b_re = op.a_re; op.b_im = op.a_im;
            end
            pending_results.push_back(complex_alu(op));
         end
         if (k > directed.size() + 1000) calm = 1'b1;
         gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= REQ_W'(op);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 20) @(posedge clock);
      if (error_count == 0) $display("complex_number_alu_top_tb: clean");
      else $display("complex_number_alu_top_tb: errors");
      $finish;
   end

endmodule

@@ complex_number_alu_top.f @@
rtl/cnalu_pkg.sv
rtl/cnalu_div_cell.sv
rtl/complex_number_alu_top.sv
rtl/cnalu_checker.sv
dv/complex_number_alu_top_tb.sv
